// ===== rtl/core/compressor_feedback_delay_unit_macros.svh =====
// ----------------------------------------------------------------------------
// compressor_feedback_delay_unit_macros
// assertion macros shared by the compressor feedback delay unit
// ----------------------------------------------------------------------------
// each macro expects i_clk and i_rst_n in the enclosing module
`ifndef COMPRESSOR_FEEDBACK_DELAY_UNIT_MACROS_SVH
`define COMPRESSOR_FEEDBACK_DELAY_UNIT_MACROS_SVH

// condition holds at every clock edge out of reset
`define CFD_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define CFD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cfd_pkg.sv =====
// ----------------------------------------------------------------------------
// cfd_pkg
// shared constants, register indexes and the configuration record
// ----------------------------------------------------------------------------
package cfd_pkg;

    localparam int DEF_DELAY_DEPTH  = 32768;
    localparam int DEF_SAMPLE_WIDTH = 24;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;
    localparam int DELAY_LEN_W = 15;
    localparam int QUEUE_DEPTH = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INVERSE_RATIO = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEFF  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEFF = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_LEFT    = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_RIGHT   = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WET_LEVEL     = 8'd7;

    // reset values
    localparam logic [15:0] RST_THRESHOLD     = 16'd16384;
    localparam logic [15:0] RST_INVERSE_RATIO = 16'd21845;
    localparam logic [23:0] RST_ATTACK_COEFF  = 24'd16777;
    localparam logic [23:0] RST_RELEASE_COEFF = 24'd1678;
    localparam logic [15:0] RST_FEEDBACK_GAIN = 16'd22938;
    localparam logic [DELAY_LEN_W-1:0] RST_DELAY_LEFT  = 15'd14880;
    localparam logic [DELAY_LEN_W-1:0] RST_DELAY_RIGHT = 15'd20640;
    localparam logic [15:0] RST_WET_LEVEL     = 16'd13107;

    // 0.3 in q16
    localparam logic [15:0] INPUT_SCALE_Q16 = 16'd19661;

    typedef struct packed {
        logic [15:0]            threshold;
        logic [15:0]            inverse_ratio;
        logic [23:0]            attack_coeff;
        logic [23:0]            release_coeff;
        logic [15:0]            feedback_gain;
        logic [DELAY_LEN_W-1:0] delay_left;
        logic [DELAY_LEN_W-1:0] delay_right;
        logic [15:0]            wet_level;
    } t_cfg;

endpackage

// ===== rtl/core/compressor_feedback_delay_unit.sv =====
// ----------------------------------------------------------------------------
// compressor_feedback_delay_unit
// compressor with envelope follower feeding left and right feedback comb delays
// ----------------------------------------------------------------------------
// One input item (a signed q4.20 voice sample) gives one output item holding a
// saturated left and right sample. The front end scales the input by 0.3,
// updates the peak envelope and, when the envelope is above the threshold,
// divides by the envelope one quotient bit per cycle. The back end runs each item
// through its two delay memories (read, feedback, write, tap read, mix), first
// subtracting DELAY_DEPTH from an oversized length until it fits. A two-item queue
// lets the front take new items while the back or the output waits. The delay
// stores read as zero until first written (tracked by a fill count), so no
// clearing pass follows reset. Configuration writes are always taken and must
// only happen while no item is in flight.
module compressor_feedback_delay_unit #(
    parameter int DELAY_DEPTH  = cfd_pkg::DEF_DELAY_DEPTH,
    parameter int SAMPLE_WIDTH = cfd_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] i_s_tdata,   // voice_mix
    // output stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] o_m_tdata, // out_left, out_right
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cfd_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [cfd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    localparam int W   = SAMPLE_WIDTH;
    localparam int MDW = ((2*SAMPLE_WIDTH+7)/8)*8;

    cfd_pkg::t_cfg       r_cfg;
    logic                push, full, pop, q_valid;
    logic signed [W-1:0] front_sig, q_sig, out_l, out_r;
    logic [W-1:0]        q_data;

    // registers are always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold     <= cfd_pkg::RST_THRESHOLD;
            r_cfg.inverse_ratio <= cfd_pkg::RST_INVERSE_RATIO;
            r_cfg.attack_coeff  <= cfd_pkg::RST_ATTACK_COEFF;
            r_cfg.release_coeff <= cfd_pkg::RST_RELEASE_COEFF;
            r_cfg.feedback_gain <= cfd_pkg::RST_FEEDBACK_GAIN;
            r_cfg.delay_left    <= cfd_pkg::RST_DELAY_LEFT;
            r_cfg.delay_right   <= cfd_pkg::RST_DELAY_RIGHT;
            r_cfg.wet_level     <= cfd_pkg::RST_WET_LEVEL;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                cfd_pkg::REG_THRESHOLD:     r_cfg.threshold     <= i_cfg_data[15:0];
                cfd_pkg::REG_INVERSE_RATIO: r_cfg.inverse_ratio <= i_cfg_data[15:0];
                cfd_pkg::REG_ATTACK_COEFF:  r_cfg.attack_coeff  <= i_cfg_data[23:0];
                cfd_pkg::REG_RELEASE_COEFF: r_cfg.release_coeff <= i_cfg_data[23:0];
                cfd_pkg::REG_FEEDBACK_GAIN: r_cfg.feedback_gain <= i_cfg_data[15:0];
                cfd_pkg::REG_DELAY_LEFT:    r_cfg.delay_left    <= i_cfg_data[14:0];
                cfd_pkg::REG_DELAY_RIGHT:   r_cfg.delay_right   <= i_cfg_data[14:0];
                cfd_pkg::REG_WET_LEVEL:     r_cfg.wet_level     <= i_cfg_data[15:0];
                default: ;  // unknown index is dropped
            endcase
        end
    end

    // gain stage
    cfd_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_sample ($signed(i_s_tdata[W-1:0])),
        .i_cfg    (r_cfg),
        .o_push   (push),
        .i_full   (full),
        .o_sig    (front_sig)
    );

    // decoupling queue
    cfd_queue #(
        .WIDTH (SAMPLE_WIDTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_sig),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign q_sig = $signed(q_data);

    // delay lines, mix and output register
    cfd_back #(
        .DELAY_DEPTH  (DELAY_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_pop     (pop),
        .i_sig     (q_sig),
        .i_cfg     (r_cfg),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_left    (out_l),
        .o_right   (out_r)
    );

    // left in the low bits, zero padded to whole bytes
    assign o_m_tdata = MDW'({out_r, out_l});

endmodule

// ===== rtl/core/cfd_front.sv =====
// ----------------------------------------------------------------------------
// cfd_front
// input scaling, envelope follower and compression gain with bit-serial divide
// ----------------------------------------------------------------------------
module cfd_front #(
    parameter int SAMPLE_WIDTH = cfd_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  cfd_pkg::t_cfg                  i_cfg,
    output logic                           o_push,
    input  logic                           i_full,
    output logic signed [SAMPLE_WIDTH-1:0] o_sig
);
    localparam int W  = SAMPLE_WIDTH;
    localparam int CW = $clog2(W + 1);
    localparam int TW = W + 12;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SCALE = 4'd1;
    localparam logic [3:0] ST_ENV   = 4'd2;
    localparam logic [3:0] ST_ENVUP = 4'd3;
    localparam logic [3:0] ST_THR   = 4'd4;
    localparam logic [3:0] ST_COMP  = 4'd5;
    localparam logic [3:0] ST_MUL   = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_FIN   = 4'd8;
    localparam logic [3:0] ST_PUSH  = 4'd9;

    localparam logic signed [W+25:0] EMAX = (W+26)'({W{1'b1}});

    logic [3:0]              r_state, n_state;
    logic signed [W-1:0]     r_x, r_sig, r_res;
    logic [W-1:0]            r_env, r_comp, r_rem, r_dlo;
    logic signed [W+25:0]    r_eprod;
    logic [W+15:0]           r_cprod;
    logic [CW-1:0]           r_cnt;

    logic signed [W+16:0]    scale_prod, scale_rnd;
    logic [W-1:0]            sig_mag, thr;
    logic [TW-1:0]           thr_wide;
    logic signed [W:0]       diff;
    logic [23:0]             coeff;
    logic signed [W+25:0]    env_rnd, env_new;
    logic [W+15:0]           comp_rnd;
    logic [2*W-1:0]          dividend;
    logic [W:0]              trial;
    logic                    qbit;

    assign o_ready = (r_state == ST_IDLE);
    assign o_push  = (r_state == ST_PUSH) && !i_full;
    assign o_sig   = r_res;

    assign scale_prod = (W+17)'(r_x) * $signed({1'b0, cfd_pkg::INPUT_SCALE_Q16});
    assign scale_rnd  = (scale_prod + (W+17)'(32768)) >>> 16;
    assign sig_mag    = r_sig[W-1] ? W'(-r_sig) : W'(r_sig);
    assign thr_wide   = {i_cfg.threshold, {(W-4){1'b0}}} >> 16;
    assign thr        = thr_wide[W-1:0];
    assign diff       = $signed({1'b0, sig_mag}) - $signed({1'b0, r_env});
    assign coeff      = (sig_mag > r_env) ? i_cfg.attack_coeff : i_cfg.release_coeff;
    assign env_rnd    = (r_eprod + (W+26)'(8388608)) >>> 24;
    assign env_new    = (W+26)'($signed({1'b0, r_env})) + env_rnd;
    assign comp_rnd   = (r_cprod + (W+16)'(32768)) >> 16;
    assign dividend   = ((2*W)'(sig_mag) * (2*W)'(r_comp)) + (2*W)'(r_env >> 1);
    assign trial      = {r_rem, r_dlo[W-1]};
    assign qbit       = (trial >= (W+1)'(r_env));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_valid) n_state = ST_SCALE;
            ST_SCALE: n_state = ST_ENV;
            ST_ENV:   n_state = ST_ENVUP;
            ST_ENVUP: n_state = ST_THR;
            ST_THR:   n_state = (r_env > thr) ? ST_COMP : ST_PUSH;
            ST_COMP:  n_state = ST_MUL;
            ST_MUL:   n_state = ST_DIV;
            ST_DIV:   if (r_cnt == CW'(1)) n_state = ST_FIN;
            ST_FIN:   n_state = ST_PUSH;
            ST_PUSH:  if (!i_full) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_env   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_ENVUP) begin
                if (env_new < 0)
                    r_env <= '0;
                else if (env_new > EMAX)
                    r_env <= {W{1'b1}};
                else
                    r_env <= env_new[W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE:  if (i_valid) r_x <= i_sample;
            ST_SCALE: r_sig <= scale_rnd[W-1:0];
            ST_ENV:   r_eprod <= (W+26)'(diff) * $signed({1'b0, coeff});
            ST_THR: begin
                r_cprod <= (W+16)'(r_env - thr) * (W+16)'(i_cfg.inverse_ratio);
                r_res   <= r_sig;
            end
            ST_COMP:  r_comp <= thr + comp_rnd[W-1:0];
            ST_MUL: begin
                // top half is already below the envelope, so w steps suffice
                r_rem <= dividend[2*W-1:W];
                r_dlo <= dividend[W-1:0];
                r_cnt <= CW'(W);
            end
            ST_DIV: begin
                r_rem <= qbit ? W'(trial - (W+1)'(r_env)) : trial[W-1:0];
                r_dlo <= {r_dlo[W-2:0], qbit};
                r_cnt <= r_cnt - CW'(1);
            end
            ST_FIN:   r_res <= r_sig[W-1] ? -$signed(r_dlo) : $signed(r_dlo);
            default: ;
        endcase
    end

endmodule

// ===== rtl/core/cfd_queue.sv =====
// ----------------------------------------------------------------------------
// cfd_queue
// small fifo between the gain stage and the delay lines
// ----------------------------------------------------------------------------
module cfd_queue #(
    parameter int WIDTH = cfd_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int QD  = cfd_pkg::QUEUE_DEPTH;
    localparam int QAW = $clog2(QD);
    localparam int QCW = $clog2(QD + 1);

    logic [WIDTH-1:0] r_mem [QD];
    logic [QAW-1:0]   r_wr, r_rd;
    logic [QCW-1:0]   r_cnt;

    assign o_full  = (r_cnt == QCW'(QD));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == QAW'(QD - 1)) ? '0 : r_wr + QAW'(1);
            if (i_pop)  r_rd <= (r_rd == QAW'(QD - 1)) ? '0 : r_rd + QAW'(1);
            if (i_push && !i_pop)
                r_cnt <= r_cnt + QCW'(1);
            else if (i_pop && !i_push)
                r_cnt <= r_cnt - QCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

endmodule

// ===== rtl/core/cfd_back.sv =====
// ----------------------------------------------------------------------------
// cfd_back
// two feedback comb delays sharing one write pointer, wet/dry mix and output
// ----------------------------------------------------------------------------
`include "compressor_feedback_delay_unit_macros.svh"

module cfd_back #(
    parameter int DELAY_DEPTH  = cfd_pkg::DEF_DELAY_DEPTH,
    parameter int SAMPLE_WIDTH = cfd_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    output logic                           o_pop,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sig,
    input  cfd_pkg::t_cfg                  i_cfg,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_left,
    output logic signed [SAMPLE_WIDTH-1:0] o_right
);
    localparam int W  = SAMPLE_WIDTH;
    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int FW = $clog2(DELAY_DEPTH + 1);
    localparam int LW = cfd_pkg::DELAY_LEN_W;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_MOD  = 3'd1;
    localparam logic [2:0] B_RD   = 3'd2;
    localparam logic [2:0] B_FB   = 3'd3;
    localparam logic [2:0] B_WR   = 3'd4;
    localparam logic [2:0] B_MIX  = 3'd5;
    localparam logic [2:0] B_SUM  = 3'd6;

    localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

    logic signed [W-1:0] r_mem_l [DELAY_DEPTH];
    logic signed [W-1:0] r_mem_r [DELAY_DEPTH];

    logic [2:0]          r_state, n_state;
    logic [AW-1:0]       r_ptr;
    logic [FW-1:0]       r_fill;
    logic [LW-1:0]       r_dl, r_dr;
    logic signed [W-1:0] r_sig;
    logic [AW-1:0]       r_rdl, r_rdr;
    logic signed [W-1:0] r_rdat_l, r_rdat_r;
    logic                r_rv_l, r_rv_r;
    logic signed [W+16:0] r_fl, r_fr;
    logic signed [W-1:0] r_wl, r_wr;
    logic                r_byp_l, r_byp_r;
    logic signed [W+17:0] r_dryp, r_wetl, r_wetr;
    logic                r_o_valid;
    logic signed [W-1:0] r_ol, r_or;

    logic [AW-1:0]       dl, dr, rd_l, rd_r, tap_l, tap_r, addr_l, addr_r;
    logic signed [W-1:0] dat_l, dat_r, tapv_l, tapv_r, wv_l, wv_r, ol, orr;
    logic signed [W+16:0] fl_rnd, fr_rnd;
    logic signed [W+17:0] ws_l, ws_r;
    logic signed [W+18:0] mx_l, mx_r;
    logic [16:0]         dry;
    logic                mod_l, mod_r, out_free;

    assign mod_l = (32'(r_dl) >= DELAY_DEPTH);
    assign mod_r = (32'(r_dr) >= DELAY_DEPTH);
    assign dl    = AW'(r_dl);
    assign dr    = AW'(r_dr);

    // read slot written d steps back, wrapping below zero
    assign rd_l = (r_ptr >= dl) ? r_ptr - dl
                : AW'((AW+1)'(r_ptr) + (AW+1)'(DELAY_DEPTH) - (AW+1)'(dl));
    assign rd_r = (r_ptr >= dr) ? r_ptr - dr
                : AW'((AW+1)'(r_ptr) + (AW+1)'(DELAY_DEPTH) - (AW+1)'(dr));
    // tap is one slot after the feedback read
    assign tap_l = (r_rdl == AW'(DELAY_DEPTH - 1)) ? '0 : r_rdl + AW'(1);
    assign tap_r = (r_rdr == AW'(DELAY_DEPTH - 1)) ? '0 : r_rdr + AW'(1);
    assign addr_l = (r_state == B_WR) ? tap_l : rd_l;
    assign addr_r = (r_state == B_WR) ? tap_r : rd_r;

    // slots not yet reached by the write pointer read as zero
    assign dat_l = r_rv_l ? r_rdat_l : '0;
    assign dat_r = r_rv_r ? r_rdat_r : '0;

    assign fl_rnd = (r_fl + (W+17)'(32768)) >>> 16;
    assign fr_rnd = (r_fr + (W+17)'(32768)) >>> 16;
    assign ws_l   = (W+18)'(r_sig) + (W+18)'(fl_rnd);
    assign ws_r   = (W+18)'(r_sig) + (W+18)'(fr_rnd);
    assign wv_l   = (ws_l > (W+18)'(SMAX)) ? SMAX : (ws_l < (W+18)'(SMIN)) ? SMIN : ws_l[W-1:0];
    assign wv_r   = (ws_r > (W+18)'(SMAX)) ? SMAX : (ws_r < (W+18)'(SMIN)) ? SMIN : ws_r[W-1:0];

    assign tapv_l = r_byp_l ? r_wl : dat_l;
    assign tapv_r = r_byp_r ? r_wr : dat_r;
    assign dry    = 17'(65536) - {1'b0, i_cfg.wet_level};

    assign mx_l = ((W+19)'(r_dryp) + (W+19)'(r_wetl) + (W+19)'(32768)) >>> 16;
    assign mx_r = ((W+19)'(r_dryp) + (W+19)'(r_wetr) + (W+19)'(32768)) >>> 16;
    assign ol   = (mx_l > (W+19)'(SMAX)) ? SMAX : (mx_l < (W+19)'(SMIN)) ? SMIN : mx_l[W-1:0];
    assign orr  = (mx_r > (W+19)'(SMAX)) ? SMAX : (mx_r < (W+19)'(SMIN)) ? SMIN : mx_r[W-1:0];

    assign out_free = !r_o_valid || i_ready;
    assign o_pop    = (r_state == B_IDLE) && i_q_valid;
    assign o_valid  = r_o_valid;
    assign o_left   = r_ol;
    assign o_right  = r_or;

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: if (i_q_valid) n_state = B_MOD;
            B_MOD:  if (!mod_l && !mod_r) n_state = B_RD;
            B_RD:   n_state = B_FB;
            B_FB:   n_state = B_WR;
            B_WR:   n_state = B_MIX;
            B_MIX:  n_state = B_SUM;
            B_SUM:  if (out_free) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_ptr     <= '0;
            r_fill    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_WR) begin
                r_ptr <= (r_ptr == AW'(DELAY_DEPTH - 1)) ? '0 : r_ptr + AW'(1);
                if (r_fill != FW'(DELAY_DEPTH)) r_fill <= r_fill + FW'(1);
            end
            if (r_state == B_SUM && out_free)
                r_o_valid <= 1'b1;
            else if (i_ready)
                r_o_valid <= 1'b0;
        end
    end

    // delay memories, one write and one registered read per cycle each
    always_ff @(posedge i_clk) begin
        if (r_state == B_WR) begin
            r_mem_l[r_ptr] <= wv_l;
            r_mem_r[r_ptr] <= wv_r;
        end
        r_rdat_l <= r_mem_l[addr_l];
        r_rdat_r <= r_mem_r[addr_r];
        r_rv_l   <= (FW'(addr_l) < r_fill);
        r_rv_r   <= (FW'(addr_r) < r_fill);
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: if (i_q_valid) begin
                r_sig <= i_sig;
                r_dl  <= i_cfg.delay_left;
                r_dr  <= i_cfg.delay_right;
            end
            B_MOD: begin
                if (mod_l) r_dl <= r_dl - LW'(DELAY_DEPTH);
                if (mod_r) r_dr <= r_dr - LW'(DELAY_DEPTH);
            end
            B_RD: begin
                r_rdl <= rd_l;
                r_rdr <= rd_r;
            end
            B_FB: begin
                r_fl <= (W+17)'(dat_l) * $signed({1'b0, i_cfg.feedback_gain});
                r_fr <= (W+17)'(dat_r) * $signed({1'b0, i_cfg.feedback_gain});
            end
            B_WR: begin
                r_wl    <= wv_l;
                r_wr    <= wv_r;
                r_byp_l <= (tap_l == r_ptr);
                r_byp_r <= (tap_r == r_ptr);
            end
            B_MIX: begin
                r_dryp <= (W+18)'(r_sig) * $signed({1'b0, dry});
                r_wetl <= (W+18)'(tapv_l) * $signed({1'b0, i_cfg.wet_level});
                r_wetr <= (W+18)'(tapv_r) * $signed({1'b0, i_cfg.wet_level});
            end
            B_SUM: if (out_free) begin
                r_ol <= ol;
                r_or <= orr;
            end
            default: ;
        endcase
    end

    `CFD_ASSERT(a_fill_bound, r_fill <= FW'(DELAY_DEPTH), "fill count past delay depth")
    `CFD_ASSERT_IMP(a_ptr_tracks_fill, r_fill != FW'(DELAY_DEPTH), FW'(r_ptr) == r_fill, "write pointer and fill count disagree")
    `CFD_ASSERT_IMP(a_bypass_len_one, (r_state == B_MIX) && r_byp_l, r_dl == LW'(1), "tap bypass without unit delay")

endmodule

// ===== test/cfd_checker.sv =====
// ----------------------------------------------------------------------------
// cfd_checker
// watches the sample, result and register channels of the compressor delay
// unit, predicts each stereo result and compares it with what comes out
// ----------------------------------------------------------------------------
module cfd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [47:0] i_m_tdata,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_addr,
    input  logic [23:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  LINE_DEPTH = 32768;
    localparam longint SAMPLE_MAX = 64'sd8388607;
    localparam longint SAMPLE_MIN = -64'sd8388608;

    logic [15:0] thr_q16, inv_ratio_q16, fb_q16, wet_q16;
    logic [23:0] attack_q24, release_q24;
    logic [14:0] len_left, len_right;

    longint envelope_lvl;
    logic [23:0] left_line  [0:LINE_DEPTH-1];
    logic [23:0] right_line [0:LINE_DEPTH-1];
    int left_wr, right_wr;

    logic [47:0] stereo_q [$];

    function automatic longint round_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(input longint v);
        if (v > SAMPLE_MAX) return SAMPLE_MAX;
        if (v < SAMPLE_MIN) return SAMPLE_MIN;
        return v;
    endfunction

    // one step of a feedback comb: read d back, write, tap d-1 back
    function automatic longint comb_step(input bit is_right, input longint sig);
        int p, d, rd, np;
        longint rdval, fed, wr;
        p = is_right ? right_wr : left_wr;
        d = is_right ? int'(len_right) : int'(len_left);
        rd = (p + LINE_DEPTH - d) % LINE_DEPTH;
        rdval = is_right ? longint'($signed(right_line[rd])) : longint'($signed(left_line[rd]));
        fed = round_shift(rdval * longint'(fb_q16), 16);
        wr = clip(sig + fed);
        np = (p + 1) % LINE_DEPTH;
        if (is_right) begin
            right_line[p] = wr[23:0];
            right_wr = np;
            return longint'($signed(right_line[(np + LINE_DEPTH - d) % LINE_DEPTH]));
        end
        left_line[p] = wr[23:0];
        left_wr = np;
        return longint'($signed(left_line[(np + LINE_DEPTH - d) % LINE_DEPTH]));
    endfunction

    function automatic logic [47:0] predict_stereo(input logic [23:0] raw);
        longint x, sig, level, coeff, thr, comp, num, mag, q, tl, tr, dry, ol, orr;
        x = longint'($signed(raw));
        sig = round_shift(x * longint'(cfd_pkg::INPUT_SCALE_Q16), 16);
        level = (sig < 0) ? -sig : sig;
        coeff = (level > envelope_lvl) ? longint'(attack_q24) : longint'(release_q24);
        envelope_lvl = envelope_lvl + round_shift((level - envelope_lvl) * coeff, 24);
        if (envelope_lvl < 0) envelope_lvl = 0;
        if (envelope_lvl > 64'sd16777215) envelope_lvl = 64'sd16777215;
        thr = longint'(thr_q16) <<< 4;
        if (envelope_lvl > thr) begin
            comp = thr + round_shift((envelope_lvl - thr) * longint'(inv_ratio_q16), 16);
            num = sig * comp;
            mag = (num < 0) ? -num : num;
            q = (mag + envelope_lvl / 2) / envelope_lvl;
            sig = (num < 0) ? -q : q;
        end
        tl = comb_step(1'b0, sig);
        tr = comb_step(1'b1, sig);
        dry = 64'sd65536 - longint'(wet_q16);
        ol = clip(round_shift(sig * dry + tl * longint'(wet_q16), 16));
        orr = clip(round_shift(sig * dry + tr * longint'(wet_q16), 16));
        return {orr[23:0], ol[23:0]};
    endfunction

    always @(posedge i_clk) begin
        logic [47:0] want;
        if (!i_rst_n) begin
            thr_q16 = cfd_pkg::RST_THRESHOLD;
            inv_ratio_q16 = cfd_pkg::RST_INVERSE_RATIO;
            attack_q24 = cfd_pkg::RST_ATTACK_COEFF;
            release_q24 = cfd_pkg::RST_RELEASE_COEFF;
            fb_q16 = cfd_pkg::RST_FEEDBACK_GAIN;
            len_left = cfd_pkg::RST_DELAY_LEFT;
            len_right = cfd_pkg::RST_DELAY_RIGHT;
            wet_q16 = cfd_pkg::RST_WET_LEVEL;
            envelope_lvl = 0;
            left_wr = 0;
            right_wr = 0;
            for (int i = 0; i < LINE_DEPTH; i++) begin
                left_line[i] = '0;
                right_line[i] = '0;
            end
            stereo_q.delete();
        end else begin
            // register writes, unknown indexes fall through
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_addr)
                    cfd_pkg::REG_THRESHOLD:     thr_q16 = i_cfg_data[15:0];
                    cfd_pkg::REG_INVERSE_RATIO: inv_ratio_q16 = i_cfg_data[15:0];
                    cfd_pkg::REG_ATTACK_COEFF:  attack_q24 = i_cfg_data;
                    cfd_pkg::REG_RELEASE_COEFF: release_q24 = i_cfg_data;
                    cfd_pkg::REG_FEEDBACK_GAIN: fb_q16 = i_cfg_data[15:0];
                    cfd_pkg::REG_DELAY_LEFT:    len_left = i_cfg_data[14:0];
                    cfd_pkg::REG_DELAY_RIGHT:   len_right = i_cfg_data[14:0];
                    cfd_pkg::REG_WET_LEVEL:     wet_q16 = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                stereo_q.push_back(predict_stereo(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                if (stereo_q.size() == 0) begin
                    $error("unexpected result item %h", i_m_tdata);
                    o_errors++;
                end else begin
                    want = stereo_q.pop_front();
                    if (want[23:0] !== i_m_tdata[23:0]) begin
                        $error("out_left expected %h actual %h", want[23:0], i_m_tdata[23:0]);
                        o_errors++;
                    end
                    if (want[47:24] !== i_m_tdata[47:24]) begin
                        $error("out_right expected %h actual %h", want[47:24],
                               i_m_tdata[47:24]);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = stereo_q.size();
    end
endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives samples and register settings into the compressor delay unit with
// random gaps and back-pressure; the checker predicts and compares results
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_addr = '0;
    logic [23:0] cfg_data = '0;

    int  errors;
    int  pending;
    int  cycles = 0;
    bit  calm = 1'b0;   // no idling on either side while set

    always #1 i_clk = ~i_clk;

    compressor_feedback_delay_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),      // voice_mix
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),      // out_left, out_right
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_addr (cfg_addr),
        .i_cfg_data (cfg_data)
    );

    cfd_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_cfg_valid(cfg_valid),
        .i_cfg_ready(cfg_ready),
        .i_cfg_addr (cfg_addr),
        .i_cfg_data (cfg_data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side back-pressure, about 27 stalls in a hundred
    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= calm || ($urandom_range(0, 99) >= 27);
    end

    // one sample item, with random idle cycles before it
    task automatic send_sample(input logic [23:0] v);
        while (!calm && $urandom_range(0, 99) < 27) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= v;
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // block drains fully before any register changes
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_all(input logic [23:0] thr, input logic [23:0] inv,
                             input logic [23:0] att, input logic [23:0] rel,
                             input logic [23:0] fb, input logic [23:0] dl,
                             input logic [23:0] dr, input logic [23:0] wet);
        write_reg(cfd_pkg::REG_THRESHOLD, thr);
        write_reg(cfd_pkg::REG_INVERSE_RATIO, inv);
        write_reg(cfd_pkg::REG_ATTACK_COEFF, att);
        write_reg(cfd_pkg::REG_RELEASE_COEFF, rel);
        write_reg(cfd_pkg::REG_FEEDBACK_GAIN, fb);
        write_reg(cfd_pkg::REG_DELAY_LEFT, dl);
        write_reg(cfd_pkg::REG_DELAY_RIGHT, dr);
        write_reg(cfd_pkg::REG_WET_LEVEL, wet);
        // an index past the register file must be ignored
        write_reg(8'd8 + 8'($urandom_range(0, 247)), 24'($urandom));
    endtask

    function automatic logic [23:0] pick_sample;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 24'($urandom);
            4, 5:       return 24'($signed($urandom_range(0, 8191)) - 4096);
            6:          return 24'($urandom_range(8000000, 8388607));
            7:          return 24'(-$signed($urandom_range(8000000, 8388608)));
            8:          return 24'd0;
            default:    return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
        endcase
    endfunction

    function automatic logic [23:0] pick_delay;
        if ($urandom_range(0, 9) == 0) return 24'($urandom);
        return 24'($urandom_range(0, 64));
    endfunction

    initial begin
        int n;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed at reset settings: extremes, sign steps, rise then fall
        send_sample(24'h000000);
        send_sample(24'h7fffff);
        send_sample(24'h800000);
        send_sample(24'h000001);
        send_sample(24'hffffff);
        for (int i = 0; i < 8; i++)
            send_sample(i[0] ? 24'h7fffff : 24'h800000);
        for (int i = 0; i < 6; i++)
            send_sample(24'h000010);
        send_sample(24'h555555);
        send_sample(24'haaaaaa);
        drain();

        // extremes: no threshold, full squash, instant envelope, shortest lines
        write_all(24'hff0000, 24'h000000, 24'hffffff, 24'hffffff,
                  24'h00ffff, 24'd0, 24'd1, 24'h00ffff);
        for (int i = 0; i < 12; i++)
            send_sample(i[1] ? 24'h7fffff : pick_sample());
        drain();

        // other extremes: threshold at top, frozen envelope, longest left line
        write_all(24'h00ffff, 24'h00ffff, 24'd0, 24'd0,
                  24'd0, 24'h007fff, 24'd2, 24'd0);
        for (int i = 0; i < 12; i++)
            send_sample(pick_sample());
        drain();

        // random settings, mostly short lines so feedback shows up
        n = 0;
        for (int ph = 0; ph < 10; ph++) begin
            write_all(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                      24'($urandom), pick_delay(), pick_delay(), 24'($urandom));
            for (int i = 0; i < 170; i++) begin
                calm = (n >= 700 && n < 950);
                send_sample(pick_sample());
                n++;
            end
            calm = 1'b0;
            drain();
        end

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
